// File: rtl/bis_pkg.sv
// Shared types and constants for the bilinear image scaler.
// No dependencies; every other file imports this package.
package bis_pkg;

  // default frame and output size limits
  localparam int DEF_MAX_SRC_WIDTH  = 128;
  localparam int DEF_MAX_SRC_HEIGHT = 128;
  localparam int DEF_MAX_DST_SIZE   = 4096;

  // fixed field widths
  localparam int STEP_W     = 23;
  localparam int FRAC_SHIFT = 16;
  localparam int COORD_W    = 12;
  localparam int PIX_W      = 32;
  localparam int CH_W       = 8;
  localparam int NUM_CH     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;

  // request tag that travels down the pipeline
  typedef struct packed {
    logic               valid;
    logic               err;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } bis_tag_t;

endpackage

// File: rtl/bis_div.sv
// Iterative restoring divider, one quotient bit per cycle, for the step ratios.
// Depends on bis_pkg for the step width.
module bis_div import bis_pkg::*; #(
  parameter int NUM_W = 23,
  parameter int DEN_W = 13
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  output logic              busy,
  output logic [STEP_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] rem_next;
  logic [DEN_W-1:0] den_q;
  logic [NUM_W-1:0] nq;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   trial;
  logic             ge;

  // shift in the next numerator bit and try the subtraction
  always_comb begin
    trial    = {rem, nq[NUM_W-1]};
    ge       = trial >= {1'b0, den_q};
    rem_next = ge ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      if (cnt == CNT_W'(NUM_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // numerator shifts out as quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      nq    <= num;
      den_q <= den;
    end else if (busy) begin
      rem <= rem_next;
      nq  <= {nq[NUM_W-2:0], ge};
    end
  end

  assign quo = STEP_W'(nq);

endmodule

// File: rtl/bis_fetch.sv
// Neighbor address stage and the four-bank frame store (row/column parity banks).
// Depends on bis_pkg for the tag type and field widths.
module bis_fetch import bis_pkg::*; #(
  parameter int MAX_SRC_WIDTH  = DEF_MAX_SRC_WIDTH,
  parameter int MAX_SRC_HEIGHT = DEF_MAX_SRC_HEIGHT,
  parameter int SWW = $clog2(DEF_MAX_SRC_WIDTH + 1),
  parameter int SHW = $clog2(DEF_MAX_SRC_HEIGHT + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  bis_tag_t         b_tag,
  input  logic             b_st,
  input  logic [6:0]       b_sc,
  input  logic [6:0]       b_sr,
  input  logic [PIX_W-1:0] b_spix,
  input  logic [31:0]      b_xfp,
  input  logic [31:0]      b_yfp,
  input  logic [SWW-1:0]   sw_c,
  input  logic [SHW-1:0]   sh_c,
  output bis_tag_t         d_tag,
  output logic [CH_W-1:0]  d_xf,
  output logic [CH_W-1:0]  d_yf,
  output logic [PIX_W-1:0] p00,
  output logic [PIX_W-1:0] p10,
  output logic [PIX_W-1:0] p01,
  output logic [PIX_W-1:0] p11
);

  localparam int CW  = $clog2(MAX_SRC_WIDTH);
  localparam int RW  = $clog2(MAX_SRC_HEIGHT);
  localparam int BCW = (CW > 1) ? CW - 1 : 1;
  localparam int BRW = (RW > 1) ? RW - 1 : 1;
  localparam int BANK_DEPTH = 2 ** (BCW + BRW);

  logic [15:0]   x0f;
  logic [15:0]   y0f;
  logic [CW-1:0] x0;
  logic [CW-1:0] x1;
  logic [RW-1:0] y0;
  logic [RW-1:0] y1;

  bis_tag_t         c_tag;
  logic             c_st;
  logic [6:0]       c_sc;
  logic [6:0]       c_sr;
  logic [PIX_W-1:0] c_spix;
  logic [CW-1:0]    c_x0;
  logic [CW-1:0]    c_x1;
  logic [RW-1:0]    c_y0;
  logic [RW-1:0]    c_y1;
  logic [CH_W-1:0]  c_xf;
  logic [CH_W-1:0]  c_yf;
  logic             c_in_frame;

  logic [3:0][PIX_W-1:0] q;
  logic                  d_px0;
  logic                  d_px1;
  logic                  d_py0;
  logic                  d_py1;

  // integer part clamped to the frame, right and bottom neighbor clamped at the edge
  always_comb begin
    x0f = b_xfp[31:16];
    y0f = b_yfp[31:16];
    x0  = (x0f >= 16'(sw_c)) ? CW'(sw_c - SWW'(1)) : CW'(x0f);
    y0  = (y0f >= 16'(sh_c)) ? RW'(sh_c - SHW'(1)) : RW'(y0f);
    x1  = ((32'(x0) + 32'd1) < 32'(sw_c)) ? x0 + CW'(1) : x0;
    y1  = ((32'(y0) + 32'd1) < 32'(sh_c)) ? y0 + RW'(1) : y0;
  end

  // stage c: neighbor coordinates
  always_ff @(posedge clk) begin
    if (rst) begin
      c_tag.valid <= 1'b0;
      c_st        <= 1'b0;
    end else if (adv) begin
      c_tag.valid <= b_tag.valid;
      c_st        <= b_st;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_tag.err <= b_tag.err;
      c_tag.col <= b_tag.col;
      c_tag.row <= b_tag.row;
      c_sc      <= b_sc;
      c_sr      <= b_sr;
      c_spix    <= b_spix;
      c_x0      <= x0;
      c_x1      <= x1;
      c_y0      <= y0;
      c_y1      <= y1;
      c_xf      <= b_xfp[15:8];
      c_yf      <= b_yfp[15:8];
    end
  end

  assign c_in_frame = (32'(c_sc) < MAX_SRC_WIDTH) && (32'(c_sr) < MAX_SRC_HEIGHT);

  // stage d: four parity banks, each read once per request
  for (genvar r = 0; r < 2; r++) begin : g_row
    for (genvar c = 0; c < 2; c++) begin : g_col
      logic [PIX_W-1:0] mem [BANK_DEPTH];
      logic [PIX_W-1:0] rd;
      logic [CW-1:0]    col_sel;
      logic [RW-1:0]    row_sel;
      logic [BCW+BRW-1:0] addr;
      logic             we;

      always_comb begin
        if (c_st) begin
          col_sel = CW'(c_sc);
          row_sel = RW'(c_sr);
        end else begin
          col_sel = (c_x0[0] == 1'(c)) ? c_x0 : c_x1;
          row_sel = (c_y0[0] == 1'(r)) ? c_y0 : c_y1;
        end
        addr = {BRW'(row_sel >> 1), BCW'(col_sel >> 1)};
        we   = adv && c_st && c_in_frame && (c_sc[0] == 1'(c)) && (c_sr[0] == 1'(r));
      end

      always_ff @(posedge clk) begin
        if (we) begin
          mem[addr] <= c_spix;
        end
        if (adv) begin
          rd <= mem[addr];
        end
      end

      assign q[r * 2 + c] = rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_tag.valid <= 1'b0;
    end else if (adv) begin
      d_tag.valid <= c_tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_tag.err <= c_tag.err;
      d_tag.col <= c_tag.col;
      d_tag.row <= c_tag.row;
      d_xf      <= c_xf;
      d_yf      <= c_yf;
      d_px0     <= c_x0[0];
      d_px1     <= c_x1[0];
      d_py0     <= c_y0[0];
      d_py1     <= c_y1[0];
    end
  end

  // route bank outputs back to neighbor positions
  assign p00 = q[{d_py0, d_px0}];
  assign p10 = q[{d_py0, d_px1}];
  assign p01 = q[{d_py1, d_px0}];
  assign p11 = q[{d_py1, d_px1}];

endmodule

// File: rtl/bis_blend.sv
// Two blend stages: horizontal lerp on both rows, then vertical lerp and output word.
// Depends on bis_pkg for the tag type and channel widths.
module bis_blend import bis_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  bis_tag_t           d_tag,
  input  logic [CH_W-1:0]    d_xf,
  input  logic [CH_W-1:0]    d_yf,
  input  logic [PIX_W-1:0]   p00,
  input  logic [PIX_W-1:0]   p10,
  input  logic [PIX_W-1:0]   p01,
  input  logic [PIX_W-1:0]   p11,
  output logic               out_valid,
  output logic [PIX_W-1:0]   out_pixel,
  output logic [COORD_W-1:0] out_col,
  output logic [COORD_W-1:0] out_row,
  output logic               coord_error
);

  // a + floor((b - a) * f / 256), taken mod 256
  function automatic logic [CH_W-1:0] lerp8(input logic [CH_W-1:0] a,
                                            input logic [CH_W-1:0] b,
                                            input logic [CH_W-1:0] f);
    logic signed [9:0]  d;
    logic signed [18:0] p;
    d = $signed({2'b00, b}) - $signed({2'b00, a});
    p = d * $signed({1'b0, f});
    return a + p[15:8];
  endfunction

  bis_tag_t                    e_tag;
  logic [CH_W-1:0]             e_yf;
  logic [NUM_CH-1:0][CH_W-1:0] top;
  logic [NUM_CH-1:0][CH_W-1:0] bot;
  logic [NUM_CH-1:0][CH_W-1:0] top_next;
  logic [NUM_CH-1:0][CH_W-1:0] bot_next;
  logic [NUM_CH-1:0][CH_W-1:0] pix_next;

  // per-channel horizontal blend
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      top_next[c] = lerp8(p00[c*CH_W +: CH_W], p10[c*CH_W +: CH_W], d_xf);
      bot_next[c] = lerp8(p01[c*CH_W +: CH_W], p11[c*CH_W +: CH_W], d_xf);
    end
  end

  // stage e
  always_ff @(posedge clk) begin
    if (rst) begin
      e_tag.valid <= 1'b0;
    end else if (adv) begin
      e_tag.valid <= d_tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_tag.err <= d_tag.err;
      e_tag.col <= d_tag.col;
      e_tag.row <= d_tag.row;
      e_yf      <= d_yf;
      top       <= top_next;
      bot       <= bot_next;
    end
  end

  // per-channel vertical blend
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      pix_next[c] = lerp8(top[c], bot[c], e_yf);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= e_tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pixel   <= e_tag.err ? '0 : pix_next;
      out_col     <= e_tag.col;
      out_row     <= e_tag.row;
      coord_error <= e_tag.err;
    end
  end

endmodule

// File: rtl/bilinear_image_scaler_core.sv
// Bilinear image scaler: holds a source frame of four-channel 32-bit pixels and
// returns bilinear output pixels at one request or store per cycle while
// in_stall is low. A word passes the input, step multiply, neighbor address,
// bank read, horizontal blend and vertical blend registers, the last being the
// output register. The frame is split into four banks by row and column parity
// so the four neighbors are read in the same cycle. After reset and after every
// write to one of the four size registers the column and row steps are
// recomputed by two bit-serial dividers, and in_stall stays high until both
// are done. Stores return no word; a request outside the output size returns
// zero with coord_error set.
module bilinear_image_scaler_core import bis_pkg::*; #(
  parameter int MAX_SRC_WIDTH  = DEF_MAX_SRC_WIDTH,
  parameter int MAX_SRC_HEIGHT = DEF_MAX_SRC_HEIGHT,
  parameter int MAX_DST_SIZE   = DEF_MAX_DST_SIZE
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  func,
  input  logic [6:0]            src_col,
  input  logic [6:0]            src_row,
  input  logic [PIX_W-1:0]      src_pixel,
  input  logic [COORD_W-1:0]    dst_col,
  input  logic [COORD_W-1:0]    dst_row,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PIX_W-1:0]      out_pixel,
  output logic [COORD_W-1:0]    out_col,
  output logic [COORD_W-1:0]    out_row,
  output logic                  coord_error
);

  localparam int SWW = $clog2(MAX_SRC_WIDTH + 1);
  localparam int SHW = $clog2(MAX_SRC_HEIGHT + 1);
  localparam int DWW = $clog2(MAX_DST_SIZE + 1);
  localparam int NCW = SWW + FRAC_SHIFT;
  localparam int NRW = SHW + FRAC_SHIFT;

  logic [7:0]            src_width;
  logic [7:0]            src_height;
  logic [CFG_DATA_W-1:0] dst_width;
  logic [CFG_DATA_W-1:0] dst_height;
  logic                  restart;
  logic                  cfg_we;

  logic [SWW-1:0] sw_c;
  logic [SHW-1:0] sh_c;
  logic [DWW-1:0] dw_c;
  logic [DWW-1:0] dh_c;

  logic [STEP_W-1:0] col_step;
  logic [STEP_W-1:0] row_step;
  logic              col_busy;
  logic              row_busy;
  logic              adv;
  logic              in_acc;

  logic               a_v;
  logic               a_func;
  logic [6:0]         a_sc;
  logic [6:0]         a_sr;
  logic [PIX_W-1:0]   a_spix;
  logic [COORD_W-1:0] a_x;
  logic [COORD_W-1:0] a_y;

  bis_tag_t           b_tag;
  logic               b_st;
  logic [6:0]         b_sc;
  logic [6:0]         b_sr;
  logic [PIX_W-1:0]   b_spix;
  logic [31:0]        b_xfp;
  logic [31:0]        b_yfp;

  bis_tag_t           d_tag;
  logic [CH_W-1:0]    d_xf;
  logic [CH_W-1:0]    d_yf;
  logic [PIX_W-1:0]   p00;
  logic [PIX_W-1:0]   p10;
  logic [PIX_W-1:0]   p01;
  logic [PIX_W-1:0]   p11;

  // configuration registers
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= 8'd128;
      src_height <= 8'd128;
      dst_width  <= 13'd128;
      dst_height <= 13'd128;
      restart    <= 1'b1;
    end else begin
      restart <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SRC_WIDTH: begin
            src_width <= cfg_data[7:0];
            restart   <= 1'b1;
          end
          REG_SRC_HEIGHT: begin
            src_height <= cfg_data[7:0];
            restart    <= 1'b1;
          end
          REG_DST_WIDTH: begin
            dst_width <= cfg_data;
            restart   <= 1'b1;
          end
          REG_DST_HEIGHT: begin
            dst_height <= cfg_data;
            restart    <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // sizes saturated to their legal ranges
  always_comb begin
    sw_c = (src_width == '0) ? SWW'(1) :
           (32'(src_width) > MAX_SRC_WIDTH) ? SWW'(MAX_SRC_WIDTH) : SWW'(src_width);
    sh_c = (src_height == '0) ? SHW'(1) :
           (32'(src_height) > MAX_SRC_HEIGHT) ? SHW'(MAX_SRC_HEIGHT) : SHW'(src_height);
    dw_c = (dst_width == '0) ? DWW'(1) :
           (32'(dst_width) > MAX_DST_SIZE) ? DWW'(MAX_DST_SIZE) : DWW'(dst_width);
    dh_c = (dst_height == '0) ? DWW'(1) :
           (32'(dst_height) > MAX_DST_SIZE) ? DWW'(MAX_DST_SIZE) : DWW'(dst_height);
  end

  // step = ((src - 1) << 16) / dst
  bis_div #(.NUM_W(NCW), .DEN_W(DWW)) u_col_div (
    .clk   (clk),
    .rst   (rst),
    .start (restart),
    .num   ({sw_c - SWW'(1), FRAC_SHIFT'(0)}),
    .den   (dw_c),
    .busy  (col_busy),
    .quo   (col_step)
  );

  bis_div #(.NUM_W(NRW), .DEN_W(DWW)) u_row_div (
    .clk   (clk),
    .rst   (rst),
    .start (restart),
    .num   ({sh_c - SHW'(1), FRAC_SHIFT'(0)}),
    .den   (dh_c),
    .busy  (row_busy),
    .quo   (row_step)
  );

  // pipeline moves whenever the output register is free or being taken
  assign adv      = !out_valid || !out_stall;
  assign in_stall = restart || col_busy || row_busy || !adv;
  assign in_acc   = in_valid && !in_stall;

  // stage a: input word
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (adv) begin
      a_v <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_func <= func;
      a_sc   <= src_col;
      a_sr   <= src_row;
      a_spix <= src_pixel;
      a_x    <= dst_col;
      a_y    <= dst_row;
    end
  end

  // stage b: map output coordinate into the source grid, range check
  always_ff @(posedge clk) begin
    if (rst) begin
      b_tag.valid <= 1'b0;
      b_st        <= 1'b0;
    end else if (adv) begin
      b_tag.valid <= a_v && a_func;
      b_st        <= a_v && !a_func;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_tag.err <= (32'(a_x) >= 32'(dw_c)) || (32'(a_y) >= 32'(dh_c));
      b_tag.col <= a_x;
      b_tag.row <= a_y;
      b_sc      <= a_sc;
      b_sr      <= a_sr;
      b_spix    <= a_spix;
      b_xfp     <= 32'(a_x) * 32'(col_step);
      b_yfp     <= 32'(a_y) * 32'(row_step);
    end
  end

  // stages c and d: neighbors and frame store
  bis_fetch #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
    .SWW            (SWW),
    .SHW            (SHW)
  ) u_fetch (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .b_tag  (b_tag),
    .b_st   (b_st),
    .b_sc   (b_sc),
    .b_sr   (b_sr),
    .b_spix (b_spix),
    .b_xfp  (b_xfp),
    .b_yfp  (b_yfp),
    .sw_c   (sw_c),
    .sh_c   (sh_c),
    .d_tag  (d_tag),
    .d_xf   (d_xf),
    .d_yf   (d_yf),
    .p00    (p00),
    .p10    (p10),
    .p01    (p01),
    .p11    (p11)
  );

  // stages e and f: blend and output register
  bis_blend u_blend (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .d_tag       (d_tag),
    .d_xf        (d_xf),
    .d_yf        (d_yf),
    .p00         (p00),
    .p10         (p10),
    .p01         (p01),
    .p11         (p11),
    .out_valid   (out_valid),
    .out_pixel   (out_pixel),
    .out_col     (out_col),
    .out_row     (out_row),
    .coord_error (coord_error)
  );

endmodule
